// File: sv/c8x_pkg.sv
package c8x_pkg;

  localparam int MEM_BYTES   = 4096;
  localparam int STACK_DEPTH = 16;
  localparam int FRAME_ROWS  = 32;

  localparam int MA  = $clog2(MEM_BYTES);
  localparam int SA  = $clog2(STACK_DEPTH);
  localparam int SPW = $clog2(STACK_DEPTH + 1);
  localparam int FA  = $clog2(FRAME_ROWS);

  localparam logic [15:0] FONT_BASE = 16'h050;
  localparam logic [15:0] PROG_BASE = 16'h200;
  localparam int          FONT_LEN  = 80;

  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_EXEC  = 2'd1;
  localparam logic [1:0] CMD_ROW   = 2'd2;
  localparam logic [1:0] CMD_READ  = 2'd3;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_OVERFLOW  = 3'd1;
  localparam logic [2:0] ST_UNDERFLOW = 3'd2;
  localparam logic [2:0] ST_END_MEM   = 3'd3;
  localparam logic [2:0] ST_BAD_OP    = 3'd4;

  localparam logic [1:0] CFG_SHIFT = 2'd0;
  localparam logic [1:0] CFG_JUMP  = 2'd1;
  localparam logic [1:0] CFG_BUMP  = 2'd2;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [11:0] addr;
    logic [7:0]  data;
    logic [7:0]  random_byte;
  } c8x_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] pc_value;
    logic [15:0] index_value;
    logic [7:0]  flag_value;
    logic [63:0] read_data;
  } c8x_out_t;

  localparam logic [7:0] GLYPHS [FONT_LEN] = '{
    8'h60, 8'hB0, 8'hD0, 8'h90, 8'h60, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
    8'h60, 8'h90, 8'h20, 8'h40, 8'hF0, 8'hE0, 8'h10, 8'h60, 8'h10, 8'hE0,
    8'h20, 8'h60, 8'hA0, 8'hF0, 8'h20, 8'hF0, 8'h80, 8'hE0, 8'h10, 8'hE0,
    8'h60, 8'h80, 8'hE0, 8'h90, 8'h60, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
    8'h60, 8'h90, 8'h60, 8'h90, 8'h60, 8'h60, 8'h90, 8'h70, 8'h10, 8'h60,
    8'h60, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
    8'h70, 8'h80, 8'h80, 8'h80, 8'h70, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
    8'hF0, 8'h80, 8'hE0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hE0, 8'h80, 8'h80
  };

  // memory contents after reset: font glyphs, zero elsewhere
  function automatic logic [7:0] font_byte(input logic [MA-1:0] a);
    logic [MA-1:0] off;
    off = a - FONT_BASE[MA-1:0];
    if (a >= FONT_BASE[MA-1:0] && off < MA'(FONT_LEN)) return GLYPHS[off[6:0]];
    return 8'h00;
  endfunction

endpackage

// File: sv/chip8_instruction_executor_top.sv
// CHIP-8 executor. Words enter on the cmd channel (cmd_valid/cmd_stall) and
// each one yields exactly one result word on the res channel
// (res_valid/res_stall). A word is taken at an edge with valid high and stall
// low. Configuration bits are written through cfg_we/cfg_index/cfg_data.
// Steps per word, from acceptance to result valid: a memory write or an
// end of memory goes straight to the result, a memory or row read waits for
// its read data, most instructions read two opcode bytes and two registers,
// BCD then writes three digits, a sprite draw reads, merges and writes back
// each row, and a register dump/load moves one register at a time. The steps
// follow the single registered read port of the main memory and register file.
// One word is worked on at a time; cmd_stall drops as soon as the sequencer
// is back in idle, even while the previous result still waits in the output
// register. A stalled result holds its value; a finished word behind it waits
// in the sequencer until the output register frees up.
// After reset a clearing pass walks every memory address, loads the font and
// zeros the rest of memory and the register file; cmd_stall stays high during
// it, configuration writes are taken as ever. Display rows clear at once.
module chip8_instruction_executor_top
  import c8x_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cmd_valid,
  output logic       cmd_stall,
  input  c8x_in_t    cmd_word,
  output logic       res_valid,
  input  logic       res_stall,
  output c8x_out_t   res_word,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic       cfg_data
);

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_RDM, S_RDF, S_F1, S_F2, S_RX, S_RY, S_RV, S_EXEC,
    S_RET, S_VWF, S_DM, S_DF, S_DW, S_LR, S_LW, S_B0, S_B1, S_B2, S_FIN
  } state_t;

  state_t state;
  logic [MA-1:0]  clr;
  logic [15:0]    pc, idx;
  logic [SPW-1:0] sp;
  logic [7:0]     vf, dly, snd;
  logic           cfg_shift, cfg_jump, cfg_bump;
  logic [FRAME_ROWS-1:0] fvalid;
  c8x_in_t        cur;
  logic [7:0]     op_hi;
  logic [15:0]    op;
  logic [7:0]     vx, vy;
  logic [4:0]     cnt;
  logic [7:0]     flag;
  logic           coll;
  logic [7:0]     hund, tens, ones;
  logic [63:0]    sprite;
  logic [6:0]     frow;
  logic [2:0]     status;
  logic [63:0]    rd;

  // memory ports
  logic          m_we;
  logic [MA-1:0] m_waddr, m_raddr;
  logic [7:0]    m_wdata, m_rdata;
  logic          v_we;
  logic [3:0]    v_waddr, v_raddr;
  logic [7:0]    v_wdata, v_rdata;
  logic          s_we;
  logic [SA-1:0] s_waddr, s_raddr;
  logic [15:0]   s_wdata, s_rdata;
  logic          f_we;
  logic [FA-1:0] f_waddr, f_raddr;
  logic [63:0]   f_wdata, f_rdata;

  c8x_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_mem (
    .clk, .we(m_we), .waddr(m_waddr), .wdata(m_wdata), .raddr(m_raddr), .rdata(m_rdata)
  );
  c8x_ram #(.WIDTH(8), .DEPTH(16)) u_vreg (
    .clk, .we(v_we), .waddr(v_waddr), .wdata(v_wdata), .raddr(v_raddr), .rdata(v_rdata)
  );
  c8x_ram #(.WIDTH(16), .DEPTH(STACK_DEPTH)) u_stack (
    .clk, .we(s_we), .waddr(s_waddr), .wdata(s_wdata), .raddr(s_raddr), .rdata(s_rdata)
  );
  c8x_ram #(.WIDTH(64), .DEPTH(FRAME_ROWS)) u_frame (
    .clk, .we(f_we), .waddr(f_waddr), .wdata(f_wdata), .raddr(f_raddr), .rdata(f_rdata)
  );

  logic [3:0]  ox, oy, on;
  logic [7:0]  onn;
  logic [11:0] onnn;
  assign ox   = op[11:8];
  assign oy   = op[7:4];
  assign on   = op[3:0];
  assign onn  = op[7:0];
  assign onnn = op[11:0];

  logic accept;
  assign accept    = (state == S_IDLE) && cmd_valid;
  assign cmd_stall = (state != S_IDLE);

  logic end_mem;
  assign end_mem = {1'b0, pc} > 17'(MEM_BYTES - 2);

  logic [15:0]   idx_plus;
  logic [MA-1:0] ls_addr;
  assign idx_plus = idx + {11'b0, cnt};
  assign ls_addr  = idx_plus[MA-1:0];

  // alu for the 8XYN group
  logic [7:0] alu_res, alu_src;
  logic [8:0] alu_sum;
  logic       alu_flag, alu_ok, alu_fl_op;
  always_comb begin
    alu_sum   = {1'b0, vx} + {1'b0, vy};
    alu_src   = cfg_shift ? vy : vx;
    alu_res   = vy;
    alu_flag  = 1'b0;
    alu_ok    = 1'b1;
    alu_fl_op = 1'b1;
    case (on)
      4'h0: begin alu_res = vy; alu_fl_op = 1'b0; end
      4'h1: begin alu_res = vx | vy; alu_fl_op = 1'b0; end
      4'h2: begin alu_res = vx & vy; alu_fl_op = 1'b0; end
      4'h3: begin alu_res = vx ^ vy; alu_fl_op = 1'b0; end
      4'h4: begin alu_res = alu_sum[7:0]; alu_flag = alu_sum[8]; end
      4'h5: begin alu_res = vx - vy; alu_flag = (vx >= vy); end
      4'h7: begin alu_res = vy - vx; alu_flag = (vy >= vx); end
      4'h6: begin alu_res = {1'b0, alu_src[7:1]}; alu_flag = alu_src[0]; end
      4'hE: begin alu_res = {alu_src[6:0], 1'b0}; alu_flag = alu_src[7]; end
      default: begin alu_ok = 1'b0; alu_fl_op = 1'b0; end
    endcase
  end

  // bcd digits: hundreds by compare, tens by reciprocal multiply
  logic [7:0]  bcd_h, bcd_r, bcd_t;
  logic [15:0] bcd_p;
  always_comb begin
    if (vx >= 8'd200) bcd_h = 8'd2;
    else if (vx >= 8'd100) bcd_h = 8'd1;
    else bcd_h = 8'd0;
    bcd_r = vx - 8'(bcd_h * 8'd100);
    bcd_p = {8'b0, bcd_r} * 16'd205;
    bcd_t = {3'b0, bcd_p[15:11]};
  end

  // sprite row placement
  logic [5:0]  dcol;
  logic [6:0]  drow;
  logic [63:0] dbits, old_row;
  assign dcol = vx[5:0];
  assign drow = {2'b0, vy[4:0]} + {2'b0, cnt};
  always_comb begin
    if (dcol <= 6'd56) dbits = {56'b0, m_rdata} << (6'd56 - dcol);
    else dbits = {56'b0, m_rdata} >> (dcol - 6'd56);
  end
  assign old_row = fvalid[frow[FA-1:0]] ? f_rdata : 64'b0;

  logic row_in;
  assign row_in = frow < 7'(FRAME_ROWS);

  logic [3:0] sx;
  assign sx = (op[15:12] == 4'hB && !cfg_jump) ? 4'h0 : ox;

  logic [7:0] exec_v;
  always_comb begin
    case (op[15:12])
      4'h6:    exec_v = onn;
      4'h7:    exec_v = vx + onn;
      4'h8:    exec_v = alu_res;
      4'hC:    exec_v = cur.random_byte & onn;
      default: exec_v = dly;
    endcase
  end

  always_comb begin
    m_we = 1'b0; m_waddr = clr; m_wdata = 8'h00;
    m_raddr = (cmd_word.cmd == CMD_EXEC) ? pc[MA-1:0] : MA'(cmd_word.addr);
    v_we = 1'b0; v_waddr = ox; v_wdata = exec_v; v_raddr = ox;
    s_we = 1'b0; s_waddr = sp[SA-1:0]; s_wdata = pc;
    s_raddr = SA'(sp - SPW'(1));
    f_we = 1'b0; f_waddr = frow[FA-1:0]; f_wdata = old_row ^ sprite;
    f_raddr = cmd_word.addr[FA-1:0];
    case (state)
      S_CLR: begin
        m_we = 1'b1; m_wdata = font_byte(clr);
        // register file clears alongside memory, addressed by the low bits of the clear counter
        v_we = 1'b1; v_waddr = clr[3:0]; v_wdata = 8'h00;
      end
      S_IDLE: begin
        if (accept && cmd_word.cmd == CMD_WRITE) begin
          m_we = 1'b1; m_waddr = MA'(cmd_word.addr); m_wdata = cmd_word.data;
        end
      end
      S_F1: m_raddr = pc[MA-1:0] + MA'(1);
      S_RX: v_raddr = sx;
      S_RY: v_raddr = oy;
      S_EXEC: begin
        case (op[15:12])
          4'h2: s_we = (sp < SPW'(STACK_DEPTH));
          4'h6, 4'h7, 4'hC: v_we = 1'b1;
          4'h8: v_we = alu_ok;
          4'hF: v_we = (onn == 8'h07);
          default: ;
        endcase
      end
      S_VWF: begin
        v_we = 1'b1; v_waddr = 4'hF; v_wdata = flag;
      end
      S_DM: m_raddr = ls_addr;
      S_DF: f_raddr = drow[FA-1:0];
      S_DW: f_we = row_in;
      S_LR: begin
        v_raddr = cnt[3:0]; m_raddr = ls_addr;
      end
      S_LW: begin
        if (onn == 8'h55) begin
          m_we = 1'b1; m_waddr = ls_addr; m_wdata = v_rdata;
        end else begin
          v_we = 1'b1; v_waddr = cnt[3:0]; v_wdata = m_rdata;
        end
      end
      S_B0: begin m_we = 1'b1; m_waddr = idx[MA-1:0]; m_wdata = hund; end
      S_B1: begin m_we = 1'b1; m_waddr = idx[MA-1:0] + MA'(1); m_wdata = tens; end
      S_B2: begin m_we = 1'b1; m_waddr = idx[MA-1:0] + MA'(2); m_wdata = ones; end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR; clr <= '0; pc <= PROG_BASE; idx <= '0; sp <= '0;
      vf <= '0; dly <= '0; snd <= '0; fvalid <= '0; res_valid <= 1'b0;
      cfg_shift <= 1'b0; cfg_jump <= 1'b0; cfg_bump <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_SHIFT: cfg_shift <= cfg_data;
          CFG_JUMP:  cfg_jump  <= cfg_data;
          CFG_BUMP:  cfg_bump  <= cfg_data;
          default: ;
        endcase
      end
      if (v_we && v_waddr == 4'hF) vf <= v_wdata;
      if (res_valid && !res_stall && state != S_FIN) res_valid <= 1'b0;
      case (state)
        S_CLR: begin
          clr <= clr + MA'(1);
          if (clr == MA'(MEM_BYTES - 1)) state <= S_IDLE;
        end
        S_IDLE: if (accept) begin
          cur <= cmd_word; status <= ST_OK; rd <= '0;
          case (cmd_word.cmd)
            CMD_WRITE: state <= S_FIN;
            CMD_EXEC: begin
              if (end_mem) begin status <= ST_END_MEM; state <= S_FIN; end
              else state <= S_F1;
            end
            CMD_ROW:  state <= S_RDF;
            default:  state <= S_RDM;
          endcase
        end
        S_RDM: begin rd <= {56'b0, m_rdata}; state <= S_FIN; end
        S_RDF: begin
          if (cur.addr < 12'(FRAME_ROWS) && fvalid[cur.addr[FA-1:0]]) rd <= f_rdata;
          state <= S_FIN;
        end
        S_F1: begin op_hi <= m_rdata; state <= S_F2; end
        S_F2: begin
          op <= {op_hi, m_rdata}; pc <= pc + 16'd2; state <= S_RX;
        end
        S_RX: state <= S_RY;
        S_RY: begin vx <= v_rdata; state <= S_RV; end
        S_RV: begin vy <= v_rdata; state <= S_EXEC; end
        S_EXEC: begin
          state <= S_FIN; cnt <= '0; coll <= 1'b0;
          case (op[15:12])
            4'h0: begin
              if (op == 16'h00E0) fvalid <= '0;
              else if (op == 16'h00EE) begin
                if (sp == '0) status <= ST_UNDERFLOW;
                else begin sp <= sp - SPW'(1); state <= S_RET; end
              end else status <= ST_BAD_OP;
            end
            4'h1: pc <= {4'h0, onnn};
            4'h2: begin
              if (sp < SPW'(STACK_DEPTH)) begin
                sp <= sp + SPW'(1); pc <= {4'h0, onnn};
              end else status <= ST_OVERFLOW;
            end
            4'h3: if (vx == onn) pc <= pc + 16'd2;
            4'h4: if (vx != onn) pc <= pc + 16'd2;
            4'h5: begin
              if (on != 4'h0) status <= ST_BAD_OP;
              else if (vx == vy) pc <= pc + 16'd2;
            end
            4'h9: begin
              if (on != 4'h0) status <= ST_BAD_OP;
              else if (vx != vy) pc <= pc + 16'd2;
            end
            4'h8: begin
              if (!alu_ok) status <= ST_BAD_OP;
              else if (alu_fl_op) begin flag <= {7'b0, alu_flag}; state <= S_VWF; end
            end
            4'hA: idx <= {4'h0, onnn};
            4'hB: pc <= {4'h0, onnn} + {8'h0, vx};
            4'hD: begin
              if (on == 4'h0) begin flag <= 8'h00; state <= S_VWF; end
              else state <= S_DM;
            end
            4'hE: status <= ST_BAD_OP;
            4'hF: begin
              case (onn)
                8'h07: ;
                8'h15: dly <= vx;
                8'h18: snd <= vx;
                8'h1E: idx <= idx + {8'h0, vx};
                8'h29: idx <= FONT_BASE + {6'h0, vx, 2'b0} + {8'h0, vx};
                8'h33: begin
                  hund <= bcd_h; tens <= bcd_t;
                  ones <= bcd_r - 8'(bcd_t * 8'd10);
                  state <= S_B0;
                end
                8'h55, 8'h65: state <= S_LR;
                default: status <= ST_BAD_OP;
              endcase
            end
            default: ;
          endcase
        end
        S_RET: begin pc <= s_rdata; state <= S_FIN; end
        S_VWF: state <= S_FIN;
        S_DM: state <= S_DF;
        S_DF: begin sprite <= dbits; frow <= drow; state <= S_DW; end
        S_DW: begin
          cnt <= cnt + 5'd1;
          if (row_in) begin
            fvalid[frow[FA-1:0]] <= 1'b1;
            if ((old_row & sprite) != 64'b0) coll <= 1'b1;
          end
          if (cnt + 5'd1 == {1'b0, on}) begin
            flag  <= {7'b0, coll | (row_in && (old_row & sprite) != 64'b0)};
            state <= S_VWF;
          end else state <= S_DM;
        end
        S_LR: state <= S_LW;
        S_LW: begin
          cnt <= cnt + 5'd1;
          if (cnt[3:0] == ox) begin
            if (cfg_bump) idx <= idx + {12'h0, ox} + 16'd1;
            state <= S_FIN;
          end else state <= S_LR;
        end
        S_B0: state <= S_B1;
        S_B1: state <= S_B2;
        S_B2: state <= S_FIN;
        S_FIN: begin
          if (!res_valid || !res_stall) begin
            res_valid <= 1'b1;
            res_word  <= '{status: status, pc_value: pc, index_value: idx,
                           flag_value: vf, read_data: rd};
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_res_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(state == S_FIN)) else $error("result without finish");
  a_sp_bound: assert property (@(posedge clk) disable iff (rst)
    sp <= SPW'(STACK_DEPTH)) else $error("stack count beyond depth");
  a_clear_quiet: assert property (@(posedge clk) disable iff (rst)
    state == S_CLR |-> !res_valid && cmd_stall) else $error("activity during clear");
  a_accept_leaves: assert property (@(posedge clk) disable iff (rst)
    (cmd_valid && !cmd_stall) |=> state != S_IDLE) else $error("accepted word dropped");
  a_fin_holds: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN && res_valid && res_stall) |=> state == S_FIN && $stable(res_word))
    else $error("result overwritten under stall");

endmodule

// File: sv/c8x_ram.sv
module c8x_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

// File: dv/chip8_instruction_executor_top_tb.sv
`timescale 1ns / 100ps

module chip8_instruction_executor_top_tb;
  import c8x_pkg::*;

  localparam int CYCLE_LIMIT = 600000;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cmd_valid = 1'b0;
  logic       cmd_stall;
  c8x_in_t    cmd_word = '0;
  logic       res_valid;
  logic       res_stall = 1'b0;
  c8x_out_t   res_word;
  logic       cfg_we = 1'b0;
  logic [1:0] cfg_index = CFG_SHIFT;
  logic       cfg_data = 1'b0;

  chip8_instruction_executor_top dut (
    .clk(clk), .rst(rst),
    .cmd_valid(cmd_valid), .cmd_stall(cmd_stall), .cmd_word(cmd_word),
    .res_valid(res_valid), .res_stall(res_stall), .res_word(res_word),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  // shadow copy of the machine
  logic [7:0]  mem_s [MEM_BYTES];
  logic [7:0]  vreg [16];
  logic [15:0] idx_s;
  logic [15:0] pc_s;
  logic [15:0] ret_stack [STACK_DEPTH];
  int          depth_s;
  logic [63:0] rows_s [FRAME_ROWS];
  logic [7:0]  delay_s;
  logic [7:0]  sound_s;
  logic        shift_vy_q;
  logic        jump_vx_q;
  logic        bump_idx_q;

  c8x_out_t pending_results [$];
  int       fails = 0;
  int       cycles = 0;
  bit       calm = 0;
  int       stall_left = 0;

  function automatic void reset_shadow();
    for (int i = 0; i < MEM_BYTES; i++) mem_s[i] = 8'h00;
    for (int i = 0; i < FONT_LEN; i++) mem_s[FONT_BASE + i] = GLYPHS[i];
    for (int i = 0; i < 16; i++) vreg[i] = 8'h00;
    for (int i = 0; i < FRAME_ROWS; i++) rows_s[i] = 64'h0;
    idx_s = 16'h0;
    pc_s = PROG_BASE;
    depth_s = 0;
    delay_s = 8'h0;
    sound_s = 8'h0;
    shift_vy_q = 1'b0;
    jump_vx_q = 1'b0;
    bump_idx_q = 1'b0;
  endfunction

  function automatic logic [2:0] run_opcode(input logic [7:0] rnd);
    logic [15:0] op;
    logic [3:0]  x, y, n;
    logic [7:0]  nn, vx, vy;
    logic [11:0] nnn, a;
    logic [8:0]  sum;
    logic [63:0] bits;
    int          col, top, r;
    if (pc_s > 16'd4094) return ST_END_MEM;
    op = {mem_s[pc_s[11:0]], mem_s[pc_s[11:0] + 12'd1]};
    pc_s = pc_s + 16'd2;
    x = op[11:8];
    y = op[7:4];
    n = op[3:0];
    nn = op[7:0];
    nnn = op[11:0];
    vx = vreg[x];
    vy = vreg[y];
    case (op[15:12])
      4'h0: begin
        if (op == 16'h00E0) begin
          for (int i = 0; i < FRAME_ROWS; i++) rows_s[i] = 64'h0;
        end else if (op == 16'h00EE) begin
          if (depth_s == 0) return ST_UNDERFLOW;
          depth_s--;
          pc_s = ret_stack[depth_s];
        end else begin
          return ST_BAD_OP;
        end
      end
      4'h1: pc_s = {4'h0, nnn};
      4'h2: begin
        if (depth_s >= STACK_DEPTH) return ST_OVERFLOW;
        ret_stack[depth_s] = pc_s;
        depth_s++;
        pc_s = {4'h0, nnn};
      end
      4'h3: if (vx == nn) pc_s = pc_s + 16'd2;
      4'h4: if (vx != nn) pc_s = pc_s + 16'd2;
      4'h5: begin
        if (n != 4'h0) return ST_BAD_OP;
        if (vx == vy) pc_s = pc_s + 16'd2;
      end
      4'h6: vreg[x] = nn;
      4'h7: vreg[x] = vx + nn;
      4'h8: begin
        case (n)
          4'h0: vreg[x] = vy;
          4'h1: vreg[x] = vx | vy;
          4'h2: vreg[x] = vx & vy;
          4'h3: vreg[x] = vx ^ vy;
          4'h4: begin
            sum = {1'b0, vx} + {1'b0, vy};
            vreg[x] = sum[7:0];
            vreg[15] = {7'h0, sum[8]};
          end
          4'h5: begin
            vreg[x] = vx - vy;
            vreg[15] = {7'h0, vx >= vy};
          end
          4'h7: begin
            vreg[x] = vy - vx;
            vreg[15] = {7'h0, vy >= vx};
          end
          4'h6: begin
            if (shift_vy_q) vx = vy;
            vreg[x] = vx >> 1;
            vreg[15] = {7'h0, vx[0]};
          end
          4'hE: begin
            if (shift_vy_q) vx = vy;
            vreg[x] = vx << 1;
            vreg[15] = {7'h0, vx[7]};
          end
          default: return ST_BAD_OP;
        endcase
      end
      4'h9: begin
        if (n != 4'h0) return ST_BAD_OP;
        if (vx != vy) pc_s = pc_s + 16'd2;
      end
      4'hA: idx_s = {4'h0, nnn};
      4'hB: pc_s = {4'h0, nnn} + {8'h0, (jump_vx_q ? vx : vreg[0])};
      4'hC: vreg[x] = rnd & nn;
      4'hD: begin
        col = vx & 63;
        top = vy & 31;
        vreg[15] = 8'h0;
        for (int i = 0; i < n; i++) begin
          a = idx_s[11:0] + i[11:0];
          bits = {56'h0, mem_s[a]};
          if (col <= 56) bits = bits << (56 - col);
          else bits = bits >> (col - 56);
          r = top + i;
          if (r < FRAME_ROWS) begin
            if ((rows_s[r] & bits) != 64'h0) vreg[15] = 8'h1;
            rows_s[r] = rows_s[r] ^ bits;
          end
        end
      end
      4'hE: return ST_BAD_OP;
      default: begin
        case (nn)
          8'h07: vreg[x] = delay_s;
          8'h15: delay_s = vx;
          8'h18: sound_s = vx;
          8'h1E: idx_s = idx_s + {8'h0, vx};
          8'h29: idx_s = FONT_BASE + 16'd5 * {8'h0, vx};
          8'h33: begin
            mem_s[idx_s[11:0]] = 8'(vx / 100);
            mem_s[idx_s[11:0] + 12'd1] = 8'((vx % 100) / 10);
            mem_s[idx_s[11:0] + 12'd2] = 8'(vx % 10);
          end
          8'h55, 8'h65: begin
            for (int i = 0; i <= x; i++) begin
              a = idx_s[11:0] + i[11:0];
              if (nn == 8'h55) mem_s[a] = vreg[i];
              else vreg[i] = mem_s[a];
            end
            if (bump_idx_q) idx_s = idx_s + {12'h0, x} + 16'd1;
          end
          default: return ST_BAD_OP;
        endcase
      end
    endcase
    return ST_OK;
  endfunction

  function automatic c8x_out_t predict_word(input c8x_in_t w);
    c8x_out_t r;
    r = '0;
    case (w.cmd)
      CMD_WRITE: mem_s[w.addr] = w.data;
      CMD_EXEC:  r.status = run_opcode(w.random_byte);
      CMD_ROW:   r.read_data = (w.addr < FRAME_ROWS) ? rows_s[w.addr[FA-1:0]] : 64'h0;
      default:   r.read_data = {56'h0, mem_s[w.addr]};
    endcase
    r.pc_value = pc_s;
    r.index_value = idx_s;
    r.flag_value = vreg[15];
    return r;
  endfunction

  // sender: optional idle burst, then hold the word until taken
  task automatic send_word(input logic [1:0] cmd, input logic [11:0] addr,
                           input logic [7:0] data, input logic [7:0] rnd);
    c8x_in_t w;
    w.cmd = cmd;
    w.addr = addr;
    w.data = data;
    w.random_byte = rnd;
    if (!calm && $urandom_range(0, 3) == 0) begin
      cmd_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    cmd_valid <= 1'b1;
    cmd_word <= w;
    do @(posedge clk); while (cmd_stall);
    pending_results.push_back(predict_word(w));
  endtask

  // place an opcode at the current program counter and run it
  task automatic run_op(input logic [15:0] op, input logic [7:0] rnd = 8'h00);
    send_word(CMD_WRITE, pc_s[11:0], op[15:8], 8'($urandom));
    send_word(CMD_WRITE, pc_s[11:0] + 12'd1, op[7:0], 8'($urandom));
    send_word(CMD_EXEC, 12'($urandom), 8'($urandom), rnd);
  endtask

  task automatic drain();
    cmd_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // leaves the write enable high; the caller drops it after the last write
  task automatic write_cfg(input logic [1:0] which, input logic val);
    cfg_we <= 1'b1;
    cfg_index <= which;
    cfg_data <= val;
    @(posedge clk);
    case (which)
      CFG_SHIFT: shift_vy_q = val;
      CFG_JUMP:  jump_vx_q = val;
      default:   bump_idx_q = val;
    endcase
  endtask

  task automatic set_cfg(input logic s, input logic j, input logic b);
    drain();
    write_cfg(CFG_SHIFT, s);
    write_cfg(CFG_JUMP, j);
    write_cfg(CFG_BUMP, b);
    cfg_we <= 1'b0;
  endtask

  task automatic report(input string what, input logic [63:0] want, input logic [63:0] got);
    $display("%0t: %s mismatch, expected %h actual %h", $time, what, want, got);
    fails++;
  endtask

  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected word, actual %h", $time, res_word);
        fails++;
      end else begin
        if (res_word.status !== pending_results[0].status)
          report("status", 64'(pending_results[0].status), 64'(res_word.status));
        if (res_word.pc_value !== pending_results[0].pc_value)
          report("pc_value", 64'(pending_results[0].pc_value), 64'(res_word.pc_value));
        if (res_word.index_value !== pending_results[0].index_value)
          report("index_value", 64'(pending_results[0].index_value),
                 64'(res_word.index_value));
        if (res_word.flag_value !== pending_results[0].flag_value)
          report("flag_value", 64'(pending_results[0].flag_value),
                 64'(res_word.flag_value));
        if (res_word.read_data !== pending_results[0].read_data)
          report("read_data", pending_results[0].read_data, res_word.read_data);
        void'(pending_results.pop_front());
      end
    end
  end

  // receiver back-pressure in bursts
  always @(posedge clk) begin
    if (rst || calm) begin
      res_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      res_stall <= 1'b1;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 9);
      res_stall <= 1'b1;
    end else begin
      res_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("chip8_instruction_executor_top_tb: FAIL");
      $finish;
    end
  end

  task automatic test_memory_port();
    send_word(CMD_READ, 12'h050, 8'h00, 8'h00);
    send_word(CMD_WRITE, 12'hFFF, 8'hFF, 8'hFF);
    send_word(CMD_READ, 12'hFFF, 8'h00, 8'h00);
    send_word(CMD_WRITE, 12'h000, 8'h00, 8'h00);
    send_word(CMD_READ, 12'h000, 8'hFF, 8'hFF);
    send_word(CMD_ROW, 12'd31, 8'h00, 8'h00);
    send_word(CMD_ROW, 12'hFFF, 8'h00, 8'h00);
  endtask

  task automatic test_alu();
    run_op(16'h60FF);
    run_op(16'h6101);
    run_op(16'h8014);   // carry out
    run_op(16'h8015);   // borrow
    run_op(16'h8017);
    run_op(16'h8011);
    run_op(16'h8012);
    run_op(16'h8013);
    run_op(16'h8010);
    run_op(16'h8016);
    run_op(16'h801E);
    run_op(16'h6FF0);
    run_op(16'h8F14);   // flag written last over the sum
    run_op(16'h7FFF);
    run_op(16'h8018);
  endtask

  task automatic test_flow();
    run_op(16'h1400);
    run_op(16'h3000);
    run_op(16'h4000);
    run_op(16'h5010);
    run_op(16'h5011);
    run_op(16'h9010);
    run_op(16'h9011);
    run_op(16'hB123);
    run_op(16'h0123);
    run_op(16'hE09E);
    run_op(16'hC0FF, 8'hA5);
    run_op(16'hAFFF);
  endtask

  task automatic test_draw();
    run_op(16'hA050);
    run_op(16'h603C);   // runs past the right edge
    run_op(16'h611E);   // runs past the bottom
    run_op(16'hD015);
    send_word(CMD_ROW, 12'd30, 8'h00, 8'h00);
    run_op(16'hD01F);   // collides
    send_word(CMD_ROW, 12'd31, 8'h00, 8'h00);
    run_op(16'h00E0);
    send_word(CMD_ROW, 12'd30, 8'h00, 8'h00);
  endtask

  task automatic test_misc();
    run_op(16'h6AFF);
    run_op(16'hAFFE);
    run_op(16'hFA33);   // bcd wraps past the top of memory
    send_word(CMD_READ, 12'h000, 8'h00, 8'h00);
    run_op(16'hFA29);
    run_op(16'hFA1E);
    run_op(16'hF255);
    run_op(16'hF265);
    run_op(16'hFA15);
    run_op(16'hFB07);
    run_op(16'hFA18);
    run_op(16'hF00A);
    run_op(16'hFAFF);
  endtask

  task automatic test_stack_limits();
    // self call fills the stack then overflows
    run_op({4'h2, pc_s[11:0]});
    repeat (STACK_DEPTH) send_word(CMD_EXEC, 12'h0, 8'h0, 8'h0);
    // self return empties it then underflows
    run_op(16'h00EE);
    repeat (STACK_DEPTH) send_word(CMD_EXEC, 12'h0, 8'h0, 8'h0);
  endtask

  task automatic test_quirks();
    set_cfg(1'b1, 1'b1, 1'b1);
    run_op(16'h6181);
    run_op(16'h6203);
    run_op(16'h8126);
    run_op(16'h812E);
    run_op(16'hB300);
    run_op(16'h6505);
    run_op(16'hA400);
    run_op(16'hF555);
    run_op(16'hF565);
    set_cfg(1'b0, 1'b0, 1'b0);
  endtask

  function automatic logic [15:0] pick_opcode();
    logic [15:0] op;
    logic [7:0]  fsel [10];
    fsel = '{8'h07, 8'h15, 8'h18, 8'h1E, 8'h29, 8'h33, 8'h55, 8'h65, 8'h0A, 8'h00};
    op = 16'($urandom);
    // keep the program counter clear of the end of memory
    if (pc_s > 16'hF00) return {4'h1, 4'h2, op[7:0]};
    case (op[15:12])
      4'h0: case ($urandom_range(0, 2))
              0: op = 16'h00E0;
              1: op = 16'h00EE;
              default: ;
            endcase
      4'h1, 4'h2, 4'hB: if (op[11:8] == 4'hF) op[11:8] = 4'($urandom_range(0, 14));
      4'h5, 4'h9: if ($urandom_range(0, 3) != 0) op[3:0] = 4'h0;
      4'hF: begin
        op[7:0] = fsel[$urandom_range(0, 9)];
        if (op[7:0] == 8'h00) op[7:0] = 8'($urandom);
      end
      default: ;
    endcase
    return op;
  endfunction

  task automatic run_random(input int count);
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 9))
        7: send_word(CMD_WRITE, 12'($urandom), 8'($urandom), 8'($urandom));
        8: send_word(CMD_ROW,
                     12'($urandom_range(0, 1) ? $urandom : $urandom_range(0, 31)),
                     8'($urandom), 8'($urandom));
        9: send_word(CMD_READ, 12'($urandom), 8'($urandom), 8'($urandom));
        default: run_op(pick_opcode(), 8'($urandom));
      endcase
    end
  endtask

  task automatic test_end_of_memory();
    run_op(16'h1FFE);
    run_op(16'h1FFF);   // last legal slot jumps beyond it
    send_word(CMD_EXEC, 12'h0, 8'h0, 8'h0);
    send_word(CMD_EXEC, 12'hFFF, 8'hFF, 8'hFF);
    send_word(CMD_READ, 12'hFFE, 8'h0, 8'h0);
  endtask

  initial begin
    reset_shadow();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    set_cfg(1'b0, 1'b0, 1'b0);
    test_memory_port();
    test_alu();
    test_flow();
    test_draw();
    test_misc();
    test_stack_limits();
    test_quirks();
    for (int p = 0; p < 5; p++) begin
      case (p)
        0: ;
        1: set_cfg(1'b1, 1'b1, 1'b1);
        default: set_cfg(1'($urandom), 1'($urandom), 1'($urandom));
      endcase
      calm = (p == 4);
      run_random(24);
    end
    test_end_of_memory();
    drain();
    repeat (60) @(posedge clk);
    if (fails == 0) begin
      $display("chip8_instruction_executor_top_tb: PASS");
    end else begin
      $display("chip8_instruction_executor_top_tb: FAIL");
    end
    $finish;
  end

endmodule

// File: files.f
sv/c8x_pkg.sv
sv/c8x_ram.sv
sv/chip8_instruction_executor_top.sv
dv/chip8_instruction_executor_top_tb.sv
